// ----- hw/rtl/cim_pkg.sv -----
// Package for the canonical interval map.
// Holds sequencer states, status codes and operation codes; no dependencies.
`default_nettype none
package cim_pkg;

  localparam int STAT_W = 2;
  localparam int CNT_W  = 6;

  typedef enum logic [0:0] {
    OP_ASSIGN = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_CP_RD,
    ST_CP_WR,
    ST_WR_B,
    ST_WR_E,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/cim_if.sv -----
// Valid/ready channel interfaces for request and response words.
// Depends on cim_pkg for the status and count widths.
`default_nettype none
interface cim_req_if #(
  parameter int KEY_WIDTH = 32,
  parameter int VAL_WIDTH = 8
);
  logic                 valid;
  logic                 ready;
  logic                 op;
  logic [KEY_WIDTH-1:0] range_begin;
  logic [KEY_WIDTH-1:0] range_end;
  logic [VAL_WIDTH-1:0] new_value;
  logic [KEY_WIDTH-1:0] query_key;

  modport source (output valid, op, range_begin, range_end, new_value, query_key,
                  input ready);
  modport sink   (input valid, op, range_begin, range_end, new_value, query_key,
                  output ready);
endinterface

interface cim_rsp_if #(
  parameter int VAL_WIDTH = 8
);
  logic                       valid;
  logic                       ready;
  logic [VAL_WIDTH-1:0]       read_value;
  logic [cim_pkg::STAT_W-1:0] status;
  logic [cim_pkg::CNT_W-1:0]  entry_count;

  modport source (output valid, read_value, status, entry_count, input ready);
  modport sink   (input valid, read_value, status, entry_count, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/cim_mem.sv -----
// Boundary table store: one write port, one registered read port.
// No dependencies.
`default_nettype none
module cim_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int KW    = 32,
  parameter int VW    = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [KW-1:0] wkey,
  input  wire logic [VW-1:0] wval,
  input  wire logic [AW-1:0] raddr,
  output logic      [KW-1:0] rkey,
  output logic      [VW-1:0] rval
);
  logic [KW-1:0] keys [DEPTH];
  logic [VW-1:0] vals [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      keys[waddr] <= wkey;
      vals[waddr] <= wval;
    end
  end

  always_ff @(posedge clk) begin
    rkey <= keys[raddr];
    rval <= vals[raddr];
  end
endmodule
`default_nettype wire

// ----- hw/rtl/canonical_interval_map.sv -----
// Canonical interval map top level: sequencer, scan compare unit, table store.
// Depends on cim_pkg, cim_req_if, cim_rsp_if and cim_mem.
//
//   channel | dir | handshake          | word
//   req     | in  | valid/ready        | op, range_begin, range_end, new_value, query_key
//   rsp     | out | valid/ready        | read_value, status, entry_count
//   cfg     | in  | cfg_wr_en          | cfg_wr_data = default_value
//
// Lookup: scan of the used entries, then check. An empty assign range skips the scan.
// Assign: as lookup, then copy of each moved upper entry, then the boundary writes.
// Scan and copy share the single read port. Reset (rst, synchronous) empties the table.
// A done word waits for a free response register; req is held off until it is loaded.
`default_nettype none
module canonical_interval_map #(
  parameter int CAPACITY  = 32,
  parameter int KEY_WIDTH = 32,
  parameter int VAL_WIDTH = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [VAL_WIDTH-1:0] cfg_wr_data,
  cim_req_if.sink                   req,
  cim_rsp_if.source                 rsp
);
  import cim_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int NW = CW + 1;

  state_t state, state_next;

  logic [VAL_WIDTH-1:0] default_value;
  logic                 op_r;
  logic [KEY_WIDTH-1:0] b_r, e_r;
  logic [VAL_WIDTH-1:0] val_r, vb, ve;
  logic [CW-1:0]        used, idx, nlo, nhi, rem;
  logic [NW-1:0]        n_r;
  logic                 pend, up;
  logic [AW-1:0]        src, dst;
  stat_t                stat_r;
  logic [VAL_WIDTH-1:0] rval_r;

  logic [KEY_WIDTH-1:0] rkey;
  logic [VAL_WIDTH-1:0] rdval;
  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  logic [KEY_WIDTH-1:0] wkey;
  logic [VAL_WIDTH-1:0] wval;

  logic [KEY_WIDTH-1:0] sgn;
  logic [KEY_WIDTH-1:0] in_b, in_e;
  logic                 dif_b, dif_e;
  logic [NW-1:0]        ins, n_calc;
  logic [CW-1:0]        hi_start, tgt;
  logic                 load_rsp;

  assign sgn   = {1'b1, {(KEY_WIDTH-1){1'b0}}};
  assign in_b  = req.range_begin ^ sgn;
  assign in_e  = ((req.op == OP_LOOKUP) ? req.query_key : req.range_end) ^ sgn;
  assign dif_b = (vb != val_r);
  assign dif_e = (ve != val_r);
  assign ins   = NW'(dif_b) + NW'(dif_e);
  assign n_calc = NW'(nlo) + NW'(nhi) + ins;
  assign hi_start = used - nhi;
  assign tgt   = nlo + CW'(ins);
  assign load_rsp = (state == ST_DONE) && (!rsp.valid || rsp.ready);

  assign req.ready = (state == ST_IDLE);

  cim_mem #(.DEPTH(CAPACITY), .AW(AW), .KW(KEY_WIDTH), .VW(VAL_WIDTH)) u_mem (
    .clk, .we, .waddr, .wkey, .wval, .raddr, .rkey, .rval(rdval)
  );

  always_comb begin
    raddr = (state == ST_CP_RD) ? src : idx[AW-1:0];
    we    = 1'b0;
    waddr = dst;
    wkey  = rkey;
    wval  = rdval;
    case (state)
      ST_CP_WR: we = 1'b1;
      ST_WR_B: begin
        we    = dif_b;
        waddr = nlo[AW-1:0];
        wkey  = b_r;
        wval  = val_r;
      end
      ST_WR_E: begin
        we    = dif_e;
        waddr = AW'(nlo + CW'(dif_b));
        wkey  = e_r;
        wval  = ve;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          if (req.op == OP_ASSIGN && in_b >= in_e) state_next = ST_DONE;
          else state_next = ST_SCAN;
        end
      end
      ST_SCAN:  if (idx == used && !pend) state_next = ST_CHECK;
      ST_CHECK: begin
        if (op_r == OP_LOOKUP || n_calc > NW'(CAPACITY)) state_next = ST_DONE;
        else if (nhi == '0 || tgt == hi_start) state_next = ST_WR_B;
        else state_next = ST_CP_RD;
      end
      ST_CP_RD: state_next = ST_CP_WR;
      ST_CP_WR: state_next = (rem == CW'(1)) ? ST_WR_B : ST_CP_RD;
      ST_WR_B:  state_next = ST_WR_E;
      ST_WR_E:  state_next = ST_DONE;
      ST_DONE:  if (load_rsp) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // config register and table count
  always_ff @(posedge clk) begin
    if (rst) begin
      default_value <= '0;
      used          <= '0;
    end else begin
      if (cfg_wr_en) default_value <= cfg_wr_data;
      if (state == ST_WR_E) used <= CW'(n_r);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        op_r   <= req.op;
        b_r    <= in_b;
        e_r    <= in_e;
        val_r  <= req.new_value;
        vb     <= default_value;
        ve     <= default_value;
        idx    <= '0;
        nlo    <= '0;
        nhi    <= '0;
        pend   <= 1'b0;
        rval_r <= '0;
        stat_r <= (req.op == OP_ASSIGN && in_b >= in_e) ? STAT_EMPTY : STAT_DONE;
      end
      ST_SCAN: begin
        if (pend) begin
          if (rkey < b_r) begin
            vb  <= rdval;
            nlo <= nlo + CW'(1);
          end
          if (rkey <= e_r) ve <= rdval;
          else nhi <= nhi + CW'(1);
        end
        pend <= (idx != used);
        if (idx != used) idx <= idx + CW'(1);
      end
      ST_CHECK: begin
        n_r <= n_calc;
        rem <= nhi;
        up  <= (tgt > hi_start);
        if (op_r == OP_LOOKUP) rval_r <= ve;
        else if (n_calc > NW'(CAPACITY)) stat_r <= STAT_FULL;
        if (tgt > hi_start) begin
          src <= AW'(used - CW'(1));
          dst <= AW'(n_calc - NW'(1));
        end else begin
          src <= hi_start[AW-1:0];
          dst <= tgt[AW-1:0];
        end
      end
      ST_CP_WR: begin
        rem <= rem - CW'(1);
        src <= up ? src - AW'(1) : src + AW'(1);
        dst <= up ? dst - AW'(1) : dst + AW'(1);
      end
      default: ;
    endcase
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load_rsp) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp.read_value  <= rval_r;
      rsp.status      <= stat_r;
      rsp.entry_count <= CNT_W'(used);
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/cim_chk.sv -----
// Port-level checker for canonical_interval_map, bound to the top level.
// Depends on cim_pkg.
`default_nettype none
module cim_chk #(
  parameter int CAPACITY  = 32,
  parameter int VAL_WIDTH = 8
) (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       req_valid,
  input wire logic                       req_ready,
  input wire logic                       rsp_valid,
  input wire logic                       rsp_ready,
  input wire logic [VAL_WIDTH-1:0]       read_value,
  input wire logic [cim_pkg::STAT_W-1:0] status,
  input wire logic [cim_pkg::CNT_W-1:0]  entry_count
);
  import cim_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response word dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (status == STAT_DONE || status == STAT_EMPTY || status == STAT_FULL))
    else $error("bad status code");

  a_assign_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != STAT_DONE |-> read_value == '0)
    else $error("read value set on rejected assign");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && CAPACITY < 64 |-> entry_count <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");
endmodule

bind canonical_interval_map cim_chk #(.CAPACITY(CAPACITY), .VAL_WIDTH(VAL_WIDTH)) u_chk (
  .clk(clk), .rst(rst),
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .read_value(rsp.read_value), .status(rsp.status), .entry_count(rsp.entry_count)
);
`default_nettype wire

// ----- verif/tb_canonical_interval_map.sv -----
// Testbench for canonical_interval_map: directed and random assign/lookup words,
// checked against an in-bench predictor of the boundary table.
// Depends on cim_pkg, cim_req_if, cim_rsp_if and the canonical_interval_map RTL.
`default_nettype none
module tb_canonical_interval_map;
  import cim_pkg::*;

  localparam int CAP      = 32;
  localparam int LATENCY  = 3 * CAP + 12;
  localparam int MAX_CYC  = 1000000;
  localparam logic signed [31:0] KMIN = 32'sh8000_0000;
  localparam logic signed [31:0] KMAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic [7:0] read_value;
    stat_t      status;
    logic [5:0] entry_count;
  } map_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = '0;

  cim_req_if #(.KEY_WIDTH(32), .VAL_WIDTH(8)) req_ch ();
  cim_rsp_if #(.VAL_WIDTH(8)) rsp_ch ();

  canonical_interval_map #(.CAPACITY(CAP), .KEY_WIDTH(32), .VAL_WIDTH(8)) i_dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .req(req_ch), .rsp(rsp_ch)
  );

  always #5 clk = ~clk;

  // predictor state
  logic signed [31:0] bound_key [CAP];
  logic [7:0]         bound_val [CAP];
  int                 bound_used;
  logic [7:0]         default_val;

  map_result_t pending_results [$];
  int errors, n_words, n_checked, n_full, n_empty, n_lookups;
  int cycles;
  int burst_left;
  bit hold_req;
  int hold_cycles;

  function automatic logic [7:0] value_at(logic signed [31:0] k, bit incl);
    logic [7:0] v;
    v = default_val;
    for (int i = 0; i < bound_used; i++) begin
      if (incl ? (bound_key[i] <= k) : (bound_key[i] < k)) v = bound_val[i];
      else break;
    end
    return v;
  endfunction

  function automatic stat_t assign_range(logic signed [31:0] b, logic signed [31:0] e,
                                         logic [7:0] val);
    logic signed [31:0] tk [CAP];
    logic [7:0] tv [CAP];
    logic [7:0] vb, ve;
    int nlo, nhi, w;
    nlo = 0; nhi = 0; w = 0;
    if (b >= e) return STAT_EMPTY;
    vb = value_at(b, 1'b0);
    ve = value_at(e, 1'b1);
    for (int i = 0; i < bound_used; i++) begin
      if (bound_key[i] < b) nlo++;
      else if (bound_key[i] > e) nhi++;
    end
    if (nlo + nhi + (vb != val) + (ve != val) > CAP) return STAT_FULL;
    for (int i = 0; i < bound_used && bound_key[i] < b; i++) begin
      tk[w] = bound_key[i]; tv[w] = bound_val[i]; w++;
    end
    if (vb != val) begin
      tk[w] = b; tv[w] = val; w++;
    end
    if (ve != val) begin
      tk[w] = e; tv[w] = ve; w++;
    end
    for (int i = 0; i < bound_used; i++) begin
      if (bound_key[i] > e && w < CAP) begin
        tk[w] = bound_key[i]; tv[w] = bound_val[i]; w++;
      end
    end
    for (int i = 0; i < w; i++) begin
      bound_key[i] = tk[i]; bound_val[i] = tv[i];
    end
    bound_used = w;
    return STAT_DONE;
  endfunction

  function automatic map_result_t predict_word(op_t op, logic [31:0] b, logic [31:0] e,
                                               logic [7:0] val, logic [31:0] q);
    map_result_t r;
    r.read_value = '0;
    r.status = STAT_DONE;
    if (op == OP_ASSIGN) r.status = assign_range($signed(b), $signed(e), val);
    else r.read_value = value_at($signed(q), 1'b1);
    r.entry_count = bound_used[5:0];
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("word %0d: %s got %0d want %0d", n_checked, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYC) begin
      $display("timeout after %0d cycles", cycles);
      $display("canonical_interval_map: mismatch");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        report("unexpected word, count", 32'(rsp_ch.entry_count), 32'd0);
      end else begin
        map_result_t want;
        want = pending_results.pop_front();
        if (rsp_ch.read_value !== want.read_value)
          report("read_value", 32'(rsp_ch.read_value), 32'(want.read_value));
        if (rsp_ch.status !== want.status)
          report("status", 32'(rsp_ch.status), 32'(want.status));
        if (rsp_ch.entry_count !== want.entry_count)
          report("entry_count", 32'(rsp_ch.entry_count), 32'(want.entry_count));
      end
      n_checked++;
    end
  end

  // receiver: stall pattern picked at random from four modes; long hold-off on request
  initial begin
    int mode;
    rsp_ch.ready = 1'b0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        rsp_ch.ready <= 1'b0;
        hold_cycles++;
        if (hold_cycles >= 400) begin
          hold_req = 1'b0;
          hold_cycles = 0;
        end
      end else begin
        if (cycles % 64 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= $urandom_range(0, 1);
          2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
          default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic send_word(op_t op, logic [31:0] b, logic [31:0] e, logic [7:0] val,
                           logic [31:0] q);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        req_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
    burst_left--;
    req_ch.valid <= 1'b1;
    req_ch.op <= op;
    req_ch.range_begin <= b;
    req_ch.range_end <= e;
    req_ch.new_value <= val;
    req_ch.query_key <= q;
    do @(posedge clk); while (!req_ch.ready);
    pending_results.push_back(predict_word(op, b, e, val, q));
    n_words++;
    if (op == OP_LOOKUP) n_lookups++;
    if (pending_results[$].status == STAT_FULL) n_full++;
    if (pending_results[$].status == STAT_EMPTY) n_empty++;
    @(negedge clk);
  endtask

  task automatic assign_word(logic [31:0] b, logic [31:0] e, logic [7:0] val);
    send_word(OP_ASSIGN, b, e, val, $urandom);
  endtask

  task automatic lookup_word(logic [31:0] q);
    send_word(OP_LOOKUP, $urandom, $urandom, 8'($urandom), q);
  endtask

  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  task automatic write_default(logic [7:0] v);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    default_val = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic test_empty_table();
    lookup_word(KMIN);
    lookup_word(KMAX);
    assign_word(KMIN, KMAX, 8'hff);
    lookup_word(KMIN);
    lookup_word(KMAX);
  endtask

  task automatic test_empty_ranges();
    assign_word(32'd5, 32'd5, 8'h11);
    assign_word(KMAX, KMIN, 8'h22);
  endtask

  task automatic test_end_boundary();
    assign_word(32'd10, 32'd20, 8'h05);
    assign_word(32'd0, 32'd10, 8'h05);
    assign_word(-32'sd5, 32'd20, 8'h07);
    lookup_word(32'd20);
  endtask

  task automatic test_table_full();
    assign_word(KMIN, KMAX, 8'h00);
    for (int i = 0; i < 17; i++) assign_word(2 * i, 2 * i + 1, 8'h01);
    lookup_word(32'd32);
  endtask

  task automatic test_default_change();
    write_default(8'h80);
    lookup_word(-32'sd100);
    lookup_word(32'd1);
    assign_word(KMIN, KMAX, 8'h80);
    write_default(8'h00);
  endtask

  task automatic test_backpressure();
    wait_idle();
    hold_req = 1'b1;
    for (int i = 0; i < 8; i++) lookup_word($urandom_range(0, 40));
  endtask

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 19))
      0: return KMIN;
      1: return KMAX;
      2, 3: return $urandom;
      default: return $urandom_range(0, 60) - 30;
    endcase
  endfunction

  task automatic test_random(int count);
    logic [31:0] b;
    logic [7:0] v;
    for (int i = 0; i < count; i++) begin
      v = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
      case ($urandom_range(0, 39))
        0: assign_word(KMIN, KMAX, v);
        1, 2: assign_word(pick_key(), pick_key(), v);
        3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16: lookup_word(pick_key());
        default: begin
          b = pick_key();
          assign_word(b, ($signed(b) > KMAX - 8) ? KMAX : b + $urandom_range(1, 8), v);
        end
      endcase
    end
  endtask

  initial begin
    errors = 0; n_words = 0; n_checked = 0; n_full = 0; n_empty = 0; n_lookups = 0;
    cycles = 0; burst_left = 0; hold_req = 1'b0; hold_cycles = 0;
    bound_used = 0; default_val = '0;
    req_ch.valid = 1'b0;
    req_ch.op = OP_ASSIGN;
    req_ch.range_begin = '0;
    req_ch.range_end = '0;
    req_ch.new_value = '0;
    req_ch.query_key = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_empty_ranges();
    test_end_boundary();
    test_table_full();
    test_default_change();
    test_backpressure();
    test_random(400);
    write_default(8'hff);
    test_random(400);
    write_default(8'($urandom));
    test_random(400);
    write_default(8'h00);
    test_random(400);

    wait_idle();
    $display("%0d words (%0d lookups), %0d checked; %0d full rejects, %0d empty ranges",
             n_words, n_lookups, n_checked, n_full, n_empty);
    $display("defaults 0, 0x80, 0xff and random; long receiver hold-off included");
    if (errors == 0) $display("canonical_interval_map: match");
    else $display("canonical_interval_map: mismatch");
    $finish;
  end
endmodule
`default_nettype wire

// ----- canonical_interval_map.f -----
hw/rtl/cim_pkg.sv
hw/rtl/cim_if.sv
hw/rtl/cim_mem.sv
hw/rtl/canonical_interval_map.sv
hw/rtl/cim_chk.sv
verif/tb_canonical_interval_map.sv
